[rtl/core/gutl_pkg.sv]
// Shared types, constants and calendar helpers for the UTC to local time pipeline.
package gutl_pkg;

	// Pipeline stage enables, one per register stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// Calendar state handed from the offset stages to the rollover stage.
	typedef struct packed {
		logic              ok;
		logic              loc;
		logic              leap;
		logic [6:0]        year_rem;
		logic [3:0]        month;
		logic [4:0]        day;
		logic signed [6:0] hsum;
		logic [5:0]        minute;
	} cal_t;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_OCT = 4'd10;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// Rounding points of |longitude| / 15 degrees, half away from zero, for steps 1..14.
	localparam logic [31:0] LON_THR [14] = '{
		32'd75000000,   32'd225000000,  32'd375000000,  32'd525000000,
		32'd675000000,  32'd825000000,  32'd975000000,  32'd1125000000,
		32'd1275000000, 32'd1425000000, 32'd1575000000, 32'd1725000000,
		32'd1875000000, 32'd2025000000
	};

	localparam logic [3:0] OFF_MAX_EAST = 4'd14;
	localparam logic [3:0] OFF_MAX_WEST = 4'd12;

	// floor(y / 100) = (y * 5243) >> 19, exact for every 12-bit year.
	localparam logic [24:0] DIV100_MUL = 25'd5243;
	localparam logic [11:0] YEARS_PER_CENTURY = 12'd100;
	// floor(s / 7) = (s * 9363) >> 16, exact for the weekday sums that occur here.
	localparam logic [25:0] DIV7_MUL = 26'd9363;
	localparam logic [12:0] DAYS_PER_WEEK = 13'd7;
	// Sakamoto table entry shared by March and November, plus the first of the month.
	localparam logic [12:0] WDAY_BIAS = 13'd3;

	localparam logic [6:0] HOURS_PER_DAY = 7'd24;
	localparam logic [6:0] LAST_YEAR_REM = 7'd99;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR,
			MONTH_JUN,
			MONTH_SEP,
			MONTH_NOV: len = 5'd30;
			default:   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[rtl/core/gutl_ctrl.sv]
// Valid bits and stage enables of the five-stage pipeline.
module gutl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output gutl_pkg::pipe_en_t en
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// A stage loads when it is empty or when its content moves on in the same cycle.
	always_comb begin
		en.s5 = !valid_s5 || m_tready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	assign s_tready = en.s1;
	assign m_tvalid = valid_s5;

endmodule

[rtl/core/gutl_offset.sv]
// Zone offset, daylight time and shifted hour: pipeline stages one to four.
module gutl_offset (
	input  logic               clk,
	input  gutl_pkg::pipe_en_t en,
	input  logic               date_valid,
	input  logic               time_valid,
	input  logic               location_valid,
	input  logic [11:0]        utc_year,
	input  logic [3:0]         utc_month,
	input  logic [4:0]         utc_day,
	input  logic [4:0]         utc_hour,
	input  logic [5:0]         utc_minute,
	input  logic signed [31:0] longitude_e7,
	output gutl_pkg::cal_t     cal_s4
);

	// Stage 1: magnitude of the longitude and year times the reciprocal of 100.
	logic        ok_s1, loc_s1, neg_s1;
	logic [11:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1, hour_s1;
	logic [5:0]  minute_s1;
	logic [31:0] mag_s1;
	logic [24:0] yprod_s1;
	logic [31:0] lon_u;

	assign lon_u = $unsigned(longitude_e7);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ok_s1     <= date_valid & time_valid;
			loc_s1    <= location_valid;
			neg_s1    <= lon_u[31];
			mag_s1    <= lon_u[31] ? (~lon_u + 32'd1) : lon_u;
			year_s1   <= utc_year;
			month_s1  <= utc_month;
			day_s1    <= utc_day;
			hour_s1   <= utc_hour;
			minute_s1 <= utc_minute;
			yprod_s1  <= 25'(utc_year) * gutl_pkg::DIV100_MUL;
		end
	end

	// Stage 2: rounded and clamped hour offset, century split, weekday sum.
	logic [5:0]  d100;
	logic [6:0]  rem100;
	logic [3:0]  q, qc;
	logic [4:0]  qext;
	logic [12:0] ssum;

	always_comb begin
		d100   = yprod_s1[24:19];
		rem100 = 7'(year_s1 - 12'(d100) * gutl_pkg::YEARS_PER_CENTURY);
		q      = 4'd0;
		for (int i = 0; i < 14; i++) begin
			if (mag_s1 >= gutl_pkg::LON_THR[i]) q = 4'(i + 1);
		end
		if (neg_s1) qc = (q > gutl_pkg::OFF_MAX_WEST) ? gutl_pkg::OFF_MAX_WEST : q;
		else qc = (q > gutl_pkg::OFF_MAX_EAST) ? gutl_pkg::OFF_MAX_EAST : q;
		qext = {1'b0, qc};
		ssum = 13'(year_s1) + 13'(year_s1[11:2]) - 13'(d100) + 13'(d100[5:2])
			+ gutl_pkg::WDAY_BIAS;
	end

	logic        ok_s2, loc_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2, hour_s2, off_s2;
	logic [5:0]  minute_s2;
	logic [12:0] ssum_s2;
	logic [6:0]  rem100_s2;
	logic [1:0]  d100_lo_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ok_s2      <= ok_s1;
			loc_s2     <= loc_s1;
			month_s2   <= month_s1;
			day_s2     <= day_s1;
			hour_s2    <= hour_s1;
			minute_s2  <= minute_s1;
			off_s2     <= neg_s1 ? (5'd0 - qext) : qext;
			ssum_s2    <= ssum;
			rem100_s2  <= rem100;
			d100_lo_s2 <= d100[1:0];
		end
	end

	// Stage 3: weekday sum times the reciprocal of 7, leap year flag.
	logic        ok_s3, loc_s3, leap_s3;
	logic [3:0]  month_s3;
	logic [4:0]  day_s3, hour_s3, off_s3;
	logic [5:0]  minute_s3;
	logic [12:0] ssum_s3;
	logic [25:0] sprod_s3;
	logic [6:0]  rem100_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3     <= ok_s2;
			loc_s3    <= loc_s2;
			month_s3  <= month_s2;
			day_s3    <= day_s2;
			hour_s3   <= hour_s2;
			minute_s3 <= minute_s2;
			off_s3    <= off_s2;
			ssum_s3   <= ssum_s2;
			rem100_s3 <= rem100_s2;
			sprod_s3  <= 26'(ssum_s2) * gutl_pkg::DIV7_MUL;
			// Divisible by 4 but not by 100, or divisible by 400.
			leap_s3   <= (rem100_s2[1:0] == 2'd0 && rem100_s2 != 7'd0)
				|| (rem100_s2 == 7'd0 && d100_lo_s2 == 2'd0);
		end
	end

	// Stage 4: weekday of the first, daylight time decision, shifted hour.
	logic [9:0]  q7;
	logic [2:0]  wday, first_sun;
	logic        dst;
	logic [6:0]  hsum;

	always_comb begin
		q7        = sprod_s3[25:16];
		wday      = 3'(ssum_s3 - 13'(q7) * gutl_pkg::DAYS_PER_WEEK);
		first_sun = (wday == 3'd0) ? 3'd1 : 3'(4'd8 - {1'b0, wday});
		if (month_s3 == gutl_pkg::MONTH_MAR) dst = day_s3 >= ({2'b00, first_sun} + 5'd7);
		else if (month_s3 == gutl_pkg::MONTH_NOV) dst = day_s3 < {2'b00, first_sun};
		else dst = month_s3 >= gutl_pkg::MONTH_APR && month_s3 <= gutl_pkg::MONTH_OCT;
		if (loc_s3) hsum = {2'b00, hour_s3} + {{2{off_s3[4]}}, off_s3} + {6'd0, dst};
		else hsum = {2'b00, hour_s3};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			cal_s4.ok       <= ok_s3;
			cal_s4.loc      <= loc_s3;
			cal_s4.leap     <= leap_s3;
			cal_s4.year_rem <= rem100_s3;
			cal_s4.month    <= month_s3;
			cal_s4.day      <= day_s3;
			cal_s4.hsum     <= $signed(hsum);
			cal_s4.minute   <= minute_s3;
		end
	end

endmodule

[rtl/core/gutl_roll.sv]
// Day, month and year rollover and the output register, pipeline stage five.
module gutl_roll (
	input  logic               clk,
	input  gutl_pkg::pipe_en_t en,
	input  gutl_pkg::cal_t     cal_s4,
	output logic               ok_s5,
	output logic [3:0]         month_s5,
	output logic [4:0]         day_s5,
	output logic [6:0]         year_s5,
	output logic [4:0]         hour_s5,
	output logic [5:0]         minute_s5
);

	logic [6:0] hs_u;
	logic       back, fwd;
	logic [4:0] len_cur;
	logic [3:0] month_prev, month_next, month_n;
	logic [6:0] yr_prev, yr_next, year_n;
	logic [4:0] day_n, hour_n;

	always_comb begin
		hs_u       = $unsigned(cal_s4.hsum);
		// The offset never moves the hour by more than one day either way.
		back       = cal_s4.loc && hs_u[6];
		fwd        = cal_s4.loc && !hs_u[6] && hs_u >= gutl_pkg::HOURS_PER_DAY;
		len_cur    = gutl_pkg::month_len(cal_s4.month, cal_s4.leap);
		month_prev = (cal_s4.month <= gutl_pkg::MONTH_JAN) ? gutl_pkg::MONTH_DEC
			: cal_s4.month - 4'd1;
		month_next = (cal_s4.month >= gutl_pkg::MONTH_DEC) ? gutl_pkg::MONTH_JAN
			: cal_s4.month + 4'd1;
		yr_prev    = (cal_s4.year_rem == 7'd0) ? gutl_pkg::LAST_YEAR_REM
			: cal_s4.year_rem - 7'd1;
		yr_next    = (cal_s4.year_rem == gutl_pkg::LAST_YEAR_REM) ? 7'd0
			: cal_s4.year_rem + 7'd1;

		month_n = cal_s4.month;
		day_n   = cal_s4.day;
		year_n  = cal_s4.year_rem;
		hour_n  = hs_u[4:0];
		if (back) begin
			hour_n = 5'(hs_u + gutl_pkg::HOURS_PER_DAY);
			if (cal_s4.day <= 5'd1) begin
				month_n = month_prev;
				// Only December wraps the year, so the leap flag still fits February.
				day_n   = gutl_pkg::month_len(month_prev, cal_s4.leap);
				if (cal_s4.month <= gutl_pkg::MONTH_JAN) year_n = yr_prev;
			end else begin
				day_n = cal_s4.day - 5'd1;
			end
		end else if (fwd) begin
			hour_n = 5'(hs_u - gutl_pkg::HOURS_PER_DAY);
			if (({1'b0, cal_s4.day} + 6'd1) > {1'b0, len_cur}) begin
				day_n   = 5'd1;
				month_n = month_next;
				if (cal_s4.month >= gutl_pkg::MONTH_DEC) year_n = yr_next;
			end else begin
				day_n = cal_s4.day + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ok_s5     <= cal_s4.ok;
			month_s5  <= cal_s4.ok ? month_n : 4'd0;
			day_s5    <= cal_s4.ok ? day_n : 5'd0;
			year_s5   <= cal_s4.ok ? year_n : 7'd0;
			hour_s5   <= cal_s4.ok ? hour_n : 5'd0;
			minute_s5 <= cal_s4.ok ? cal_s4.minute : 6'd0;
		end
	end

endmodule

[rtl/core/gps_utc_to_local_date_time_top.sv]
// Top level of the UTC to local date and time converter.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   UTC date, time, longitude; validity flags in tuser
//   m_*       out        m_tvalid/m_tready   local date and time; ok flag in tuser
//
// One transfer in and one transfer out per cycle when both sides are ready.
// There are five register stages: longitude magnitude and
// century product, offset rounding, weekday product, daylight decision, rollover.
// A stage loads whenever it is empty or its content moves on, so a stall on m_tready
// backs up stage by stage and bubbles still fill. Reset clears only the valid bits.
module gps_utc_to_local_date_time_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], longitude_e7[63:32]
	input  logic [63:0] s_tdata,
	// date_valid[0], time_valid[1], location_valid[2]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// local_month[3:0], local_day[8:4], year_two_digit[15:9], local_hour[20:16],
	// local_minute[26:21], zero[31:27]
	output logic [31:0] m_tdata,
	// ok[0]
	output logic [0:0]  m_tuser
);

	gutl_pkg::pipe_en_t en;
	gutl_pkg::cal_t     cal_s4;
	logic               ok_s5;
	logic [3:0]         month_s5;
	logic [4:0]         day_s5, hour_s5;
	logic [6:0]         year_s5;
	logic [5:0]         minute_s5;

	gutl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	gutl_offset u_offset (
		.clk            (clk),
		.en             (en),
		.date_valid     (s_tuser[0]),
		.time_valid     (s_tuser[1]),
		.location_valid (s_tuser[2]),
		.utc_year       (s_tdata[11:0]),
		.utc_month      (s_tdata[15:12]),
		.utc_day        (s_tdata[20:16]),
		.utc_hour       (s_tdata[25:21]),
		.utc_minute     (s_tdata[31:26]),
		.longitude_e7   ($signed(s_tdata[63:32])),
		.cal_s4         (cal_s4)
	);

	gutl_roll u_roll (
		.clk       (clk),
		.en        (en),
		.cal_s4    (cal_s4),
		.ok_s5     (ok_s5),
		.month_s5  (month_s5),
		.day_s5    (day_s5),
		.year_s5   (year_s5),
		.hour_s5   (hour_s5),
		.minute_s5 (minute_s5)
	);

	assign m_tdata = {5'd0, minute_s5, hour_s5, year_s5, day_s5, month_s5};
	assign m_tuser = ok_s5;

endmodule

[rtl/core/gutl_checker.sv]
// Port-level checks of the converter, bound to the top level.
module gutl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A result that waits keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An empty output stage means the whole pipeline can load.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled although the output stage is empty");

	// Without a valid date and time every field is zero.
	a_not_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("fields not cleared for an invalid timestamp");

	// The two-digit year stays a decimal residue and the padding stays clear.
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] <= 7'd99 && m_tdata[31:27] == 5'd0)
		else $error("two-digit year or padding out of range");

endmodule

bind gps_utc_to_local_date_time_top gutl_checker u_gutl_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the UTC to local date and time converter.
module testbench;

	localparam int IDLE_PCT       = 15;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int HOLD_AT_ITEM   = 500;
	localparam int HOLD_CYCLES    = 60;
	localparam int PAUSE_AT_ITEM  = 1300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int DIRECTED_ROWS  = 26;

	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int SAKAMOTO [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	// Fields from the most significant bit down, so that {tuser, tdata} maps onto them.
	typedef struct packed {
		logic               location_valid;
		logic               time_valid;
		logic               date_valid;
		logic signed [31:0] lon_e7;
		logic [5:0]         minute;
		logic [4:0]         hour;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [11:0]        year;
	} utc_item_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] pad;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [6:0] year2;
		logic [4:0] day;
		logic [3:0] month;
	} local_item_t;

	typedef struct packed {
		logic               dv;
		logic               tv;
		logic               lv;
		logic [11:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic signed [31:0] lon;
		logic               typed;
		logic               ok;
		logic [3:0]         lmonth;
		logic [4:0]         lday;
		logic [6:0]         lyear;
		logic [4:0]         lhour;
		logic [5:0]         lminute;
	} stim_row_t;

	// Rows with typed set carry their expected result; the others go through the predictor.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{0, 1, 1, 2024, 6, 15, 12, 30, 1234567, 1, 0, 0, 0, 0, 0, 0},
		'{1, 0, 1, 2024, 6, 15, 12, 30, -1234567, 1, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 2099, 12, 31, 23, 59, 1800000000, 1, 0, 0, 0, 0, 0, 0},
		'{1, 1, 0, 2099, 12, 31, 23, 59, -1800000000, 1, 1, 12, 31, 99, 23, 59},
		'{1, 1, 0, 2000, 1, 1, 0, 0, 1800000000, 1, 1, 1, 1, 0, 0, 0},
		'{1, 1, 1, 2023, 1, 15, 10, 45, 0, 1, 1, 1, 15, 23, 10, 45},
		'{1, 1, 1, 2023, 1, 15, 10, 45, 74999999, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2023, 1, 15, 10, 45, 75000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2023, 1, 15, 10, 45, -74999999, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2023, 1, 15, 10, 45, -75000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2099, 12, 31, 23, 59, 1800000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2000, 1, 1, 0, 0, -1800000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 3, 9, 12, 0, -1200000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 3, 10, 12, 0, -1200000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 11, 2, 3, 0, -750000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 11, 3, 3, 0, -750000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 2, 28, 20, 0, 1350000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2023, 2, 28, 20, 0, 1350000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2024, 3, 1, 2, 30, -750000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2050, 8, 31, 22, 15, 2147483647, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2050, 1, 1, 1, 15, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2060, 0, 1, 0, 10, -1800000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 2060, 15, 31, 31, 59, 1800000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 0, 1, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 0, 1, 1, 0, 0, -1800000000, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 4095, 12, 31, 23, 0, 1800000000, 0, 0, 0, 0, 0, 0, 0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	local_item_t expected_local_q [$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int          stall_cycles = 0;
	bit          tx_steady = 1'b0;

	gps_utc_to_local_date_time_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int month_days(input int y, input int m);
		// Months outside the calendar are treated as 31 days long.
		if (m < int'(gutl_pkg::MONTH_JAN) || m > int'(gutl_pkg::MONTH_DEC))
			return 31;
		if (m == int'(gutl_pkg::MONTH_FEB) && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
			return 29;
		return MONTH_DAYS[m - 1];
	endfunction

	// Day of month of the nth Sunday; only used for March and November, so no year shift.
	function automatic int nth_sunday(input int y, input int m, input int nth);
		int wday;
		wday = (y + y / 4 - y / 100 + y / 400 + SAKAMOTO[m - 1] + 1) % 7;
		return ((wday == 0) ? 1 : 8 - wday) + (nth - 1) * 7;
	endfunction

	function automatic bit summer_time(input int y, input int m, input int d);
		if (m < int'(gutl_pkg::MONTH_MAR) || m > int'(gutl_pkg::MONTH_NOV))
			return 1'b0;
		if (m > int'(gutl_pkg::MONTH_MAR) && m < int'(gutl_pkg::MONTH_NOV))
			return 1'b1;
		if (m == int'(gutl_pkg::MONTH_MAR))
			return d >= nth_sunday(y, m, 2);
		return d < nth_sunday(y, m, 1);
	endfunction

	function automatic local_item_t to_local(input utc_item_t u);
		local_item_t r;
		int          y, m, d, h, zone;
		longint      lon, mag, steps;
		r = '0;
		if (!u.date_valid || !u.time_valid)
			return r;
		y = u.year;
		m = u.month;
		d = u.day;
		h = u.hour;
		if (u.location_valid) begin
			lon = u.lon_e7;
			mag = (lon < 0) ? -lon : lon;
			// Rounds |lon| / 15 degrees half away from zero.
			steps = (mag + 75000000) / 150000000;
			zone = int'((lon < 0) ? -steps : steps);
			if (zone > 14)
				zone = 14;
			if (zone < -12)
				zone = -12;
			if (summer_time(y, m, d))
				zone++;
			h += zone;
			while (h < 0) begin
				h += 24;
				d--;
				if (d < 1) begin
					m--;
					if (m < 1) begin
						m = 12;
						y--;
					end
					d = month_days(y, m);
				end
			end
			while (h >= 24) begin
				h -= 24;
				d++;
				if (d > month_days(y, m)) begin
					d = 1;
					m++;
					if (m > 12) begin
						m = 1;
						y++;
					end
				end
			end
		end
		r.ok = 1'b1;
		r.month = 4'(m);
		r.day = 5'(d);
		r.year2 = 7'(((y % 100) + 100) % 100);
		r.hour = 5'(h);
		r.minute = u.minute;
		return r;
	endfunction

	task automatic send_utc(input utc_item_t u, input local_item_t want);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		{s_tuser, s_tdata} <= u;
		do
			@(posedge clk);
		while (!s_tready);
		expected_local_q.push_back(want);
		sent_count <= sent_count + 1;
	endtask

	initial begin : drive_utc
		utc_item_t   u;
		local_item_t want;
		stim_row_t   row;
		int          mdays;
		int          step;
		longint      lon;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			u = '{location_valid: row.lv, time_valid: row.tv, date_valid: row.dv,
				lon_e7: row.lon, minute: row.minute, hour: row.hour, day: row.day,
				month: row.month, year: row.year};
			if (row.typed)
				want = '{ok: row.ok, pad: '0, minute: row.lminute, hour: row.lhour,
					year2: row.lyear, day: row.lday, month: row.lmonth};
			else
				want = to_local(u);
			send_utc(u, want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_steady = (n >= 700 && n < 1000);
			// Let the pipeline run dry once before going on.
			if (n == PAUSE_AT_ITEM) begin
				while (expected_local_q.size() != 0) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
			u = '0;
			u.date_valid = ($urandom_range(99) >= 5);
			u.time_valid = ($urandom_range(99) >= 5);
			u.location_valid = ($urandom_range(99) >= 10);
			if ($urandom_range(15) == 0) begin
				// Fields anywhere in their bit widths, calendar or not.
				u.year = 12'($urandom);
				u.month = 4'($urandom);
				u.day = 5'($urandom);
				u.hour = 5'($urandom);
				u.minute = 6'($urandom);
				u.lon_e7 = $urandom;
			end else begin
				u.year = 12'($urandom_range(2099, 2000));
				u.month = 4'($urandom_range(12, 1));
				if ($urandom_range(3) == 0)
					u.month = $urandom_range(1) ? gutl_pkg::MONTH_MAR : gutl_pkg::MONTH_NOV;
				mdays = month_days(u.year, u.month);
				case ($urandom_range(3))
					0: u.day = 5'(mdays);
					1: u.day = 5'd1;
					2: u.day = 5'($urandom_range(14, 1));
					default: u.day = 5'($urandom_range(mdays, 1));
				endcase
				case ($urandom_range(3))
					0: u.hour = 5'($urandom_range(2));
					1: u.hour = 5'($urandom_range(23, 21));
					default: u.hour = 5'($urandom_range(23));
				endcase
				u.minute = 6'($urandom_range(59));
				if ($urandom_range(2) == 0) begin
					// Just around a rounding point of the zone offset.
					step = $urandom_range(11);
					lon = 75000000 + step * 150000000 + $urandom_range(2) - 1;
					if ($urandom_range(1))
						lon = -lon;
				end else begin
					lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
				end
				u.lon_e7 = 32'(lon);
			end
			send_utc(u, to_local(u));
		end

		s_tvalid <= 1'b0;
		while (expected_local_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_local_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : drive_ready
		int rx_cycle;
		bit held;
		rx_cycle = 0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			rx_cycle++;
			// One long hold-off while the sender keeps offering, so the input backs up.
			if (!held && sent_count >= HOLD_AT_ITEM) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= (rx_cycle >= 1500 && rx_cycle < 2300)
				|| ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		local_item_t got;
		local_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (expected_local_q.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display({"unexpected transfer: ok=%0d month=%0d day=%0d year=%0d",
						" hour=%0d min=%0d"},
						got.ok, got.month, got.day, got.year2, got.hour, got.minute);
				mismatch_count++;
			end else begin
				want = expected_local_q.pop_front();
				if (got.ok !== want.ok || got.month !== want.month || got.day !== want.day ||
						got.year2 !== want.year2 || got.hour !== want.hour ||
						got.minute !== want.minute || got.pad !== want.pad) begin
					if (mismatch_count < MAX_REPORTS)
						$display({"mismatch: expected ok=%0d month=%0d day=%0d year=%0d",
							" hour=%0d min=%0d pad=%0d, got ok=%0d month=%0d day=%0d",
							" year=%0d hour=%0d min=%0d pad=%0d"},
							want.ok, want.month, want.day, want.year2, want.hour, want.minute,
							want.pad, got.ok, got.month, got.day, got.year2, got.hour,
							got.minute, got.pad);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/core/gutl_pkg.sv
rtl/core/gutl_ctrl.sv
rtl/core/gutl_offset.sv
rtl/core/gutl_roll.sv
rtl/core/gps_utc_to_local_date_time_top.sv
rtl/core/gutl_checker.sv
tb/testbench.sv
